/* hdl/assert_macros.svh */
// assertion macros used by the rtl top file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold whenever not in reset
`define CHK_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);
// implication whose consequent is checked in the next cycle
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

/* hdl/vrp_pkg.sv */
// shared types and constants for the video register port
// no dependencies
package vrp_pkg;
   localparam int NAME_RAM_BYTES = 2048;
   localparam int SPRITE_MEM_BYTES = 256;
   localparam int PALETTE_ENTRIES = 32;
   localparam int NAME_AW = $clog2(NAME_RAM_BYTES);
   localparam int SPRITE_AW = $clog2(SPRITE_MEM_BYTES);
   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

   localparam logic [2:0] CMD_READ = 3'd0;
   localparam logic [2:0] CMD_WRITE = 3'd1;
   localparam logic [2:0] CMD_VBLANK = 3'd2;
   localparam logic [2:0] CMD_PRERENDER = 3'd3;
   localparam logic [2:0] CMD_HIT = 3'd4;
   localparam logic [2:0] CMD_OVERFLOW = 3'd5;

   localparam logic [2:0] REG_CTRL = 3'd0;
   localparam logic [2:0] REG_MASK = 3'd1;
   localparam logic [2:0] REG_STATUS = 3'd2;
   localparam logic [2:0] REG_OAMADDR = 3'd3;
   localparam logic [2:0] REG_OAMDATA = 3'd4;
   localparam logic [2:0] REG_SCROLL = 3'd5;
   localparam logic [2:0] REG_ADDR = 3'd6;
   localparam logic [2:0] REG_DATA = 3'd7;

   // byte address of the mirroring mode register
   localparam logic [1:0] CSR_MIRROR = 2'd0;

   typedef struct packed {
      logic [2:0] command;
      logic [2:0] reg_select;
      logic [7:0] write_data;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic nmi_pulse;
      logic pattern_access;
      logic [12:0] pattern_address;
      logic [15:0] scroll_address;
      logic [2:0] fine_scroll_x;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;   // latch request
      logic execute;   // perform the update
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic busy;
   } stat_type;

   function automatic logic [PAL_AW-1:0] pal_index(input logic [15:0] a);
      logic [4:0] i;
      i = a[4:0];
      if ((i & 5'h13) == 5'h10) i = i & 5'h0C;
      return i;
   endfunction

   function automatic logic [NAME_AW-1:0] name_index(input logic [15:0] a,
                                                     input logic [1:0] mode);
      logic [11:0] rel;
      logic bank;
      rel = a[11:0];
      case (mode)
         2'd0: bank = rel[11];
         2'd1: bank = rel[10];
         2'd2: bank = 1'b0;
         default: bank = 1'b1;
      endcase
      return {bank, rel[9:0]};
   endfunction
endpackage

/* hdl/video_register_port_top.sv */
// Video register port. Each transfer on req_ is either a CPU register access
// or a video timing event, and yields exactly one rsp_ transfer. An item passes
// through capture (with registered memory read), then execute (with write-back),
// then a state in which the result is offered; no new item is taken until that
// result has been taken, and rsp_ready low holds the block in that state.
// After reset a clearing pass zeroes nametable and object memory, one entry per
// cycle; req_ready stays low meanwhile. The mirroring mode register sits at APB
// address 0.
// depends on vrp_pkg, vrp_ctrl, vrp_datapath, assert_macros.svh
`include "assert_macros.svh"
module video_register_port_top (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  vrp_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_ready,
   output vrp_pkg::rsp_type rsp_data,
   input  logic psel,
   input  logic penable,
   input  logic pwrite,
   input  logic [1:0] paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic pready
);
   import vrp_pkg::*;

   cmd_type cmd;
   stat_type stat;
   logic [1:0] mirror_ff;
   logic clearing;

   // apb register: only one, at address 0
   assign pready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) mirror_ff <= 2'd0;
      else if (psel && penable && pwrite && paddr == CSR_MIRROR)
         mirror_ff <= pwdata[1:0];
   end
   assign prdata = (paddr == CSR_MIRROR) ? {30'd0, mirror_ff} : 32'd0;

   // sequencer
   vrp_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .cmd(cmd), .stat(stat)
   );

   // state and memories
   vrp_datapath u_dp (
      .clock(clock), .reset(reset),
      .cmd(cmd), .stat(stat),
      .req_data(req_data), .rsp_data(rsp_data),
      .mirror_mode(mirror_ff), .clearing(clearing)
   );

   // no transfer accepted during the clearing pass
   `CHK_ALWAYS(a_no_accept_clear, clock, reset, !(clearing && req_valid && req_ready), "accept while clearing")
   // an accepted transfer is never answered in the next cycle
   `CHK_NEXT(a_no_early_rsp, clock, reset, req_valid && req_ready, !rsp_valid, "response too early")
   // input and output never both open
   `CHK_ALWAYS(a_exclusive, clock, reset, !(req_ready && rsp_valid), "ready while result pending")
endmodule

/* hdl/vrp_ctrl.sv */
// sequencing of one transfer: capture, execute, hold result
// depends on vrp_pkg
module vrp_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input  logic rsp_ready,
   output vrp_pkg::cmd_type cmd,
   input  vrp_pkg::stat_type stat
);
   import vrp_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_EXEC = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE) && !stat.busy;
   assign rsp_valid = (state_ff == ST_DONE);
   assign cmd.capture = req_valid && req_ready;
   assign cmd.execute = (state_ff == ST_EXEC);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (cmd.capture) state_in = ST_EXEC;
         ST_EXEC: state_in = ST_DONE;
         ST_DONE: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end
endmodule

/* hdl/vrp_datapath.sv */
// registers, memories and update logic of the register window
// depends on vrp_pkg
module vrp_datapath (
   input  logic clock,
   input  logic reset,
   input  vrp_pkg::cmd_type cmd,
   output vrp_pkg::stat_type stat,
   input  vrp_pkg::req_type req_data,
   output vrp_pkg::rsp_type rsp_data,
   input  logic [1:0] mirror_mode,
   output logic clearing
);
   import vrp_pkg::*;

   logic [7:0] name_ram [NAME_RAM_BYTES];
   logic [7:0] sprite_mem [SPRITE_MEM_BYTES];
   logic [5:0] palette_ff [PALETTE_ENTRIES];

   logic [NAME_AW:0] clr_cnt_ff;
   req_type req_ff;

   logic [7:0] ctrl_ff, ctrl_in;
   logic [2:0] status_ff, status_in;
   logic hit_ff, hit_in;
   logic [7:0] oam_addr_ff, oam_addr_in;
   logic [15:0] v_ff, v_in;
   logic [14:0] t_ff, t_in;
   logic [2:0] fine_x_ff, fine_x_in;
   logic toggle_ff, toggle_in;
   logic [7:0] buf_ff, buf_in;
   rsp_type rsp_ff, rsp_in;

   logic [7:0] name_rd_ff, spr_rd_ff;
   logic [NAME_AW-1:0] name_addr;
   logic [PAL_AW-1:0] pal_addr;
   logic name_we, spr_we, pal_we;
   logic [15:0] v_step;

   assign clearing = !clr_cnt_ff[NAME_AW];
   assign stat.busy = clearing;
   assign name_addr = name_index(v_ff, mirror_mode);
   assign pal_addr = pal_index(v_ff);
   assign v_step = v_ff + (ctrl_ff[2] ? 16'd32 : 16'd1);

   // request registered on capture; memory reads registered unconditionally, used in execute
   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req_data;
      name_rd_ff <= name_ram[name_addr];
      spr_rd_ff <= sprite_mem[oam_addr_ff];
      if (clearing) begin
         name_ram[clr_cnt_ff[NAME_AW-1:0]] <= 8'd0;
         sprite_mem[clr_cnt_ff[SPRITE_AW-1:0]] <= 8'd0;
      end else begin
         if (name_we) name_ram[name_addr] <= req_ff.write_data;
         if (spr_we) sprite_mem[oam_addr_ff] <= req_ff.write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PALETTE_ENTRIES; i++) palette_ff[i] <= '0;
      end else if (pal_we) begin
         palette_ff[pal_addr] <= req_ff.write_data[5:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (clearing) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_comb begin
      logic in_pal, in_pat;
      in_pal = (v_ff >= 16'h3F00);
      in_pat = (v_ff < 16'h2000);
      ctrl_in = ctrl_ff; status_in = status_ff; hit_in = hit_ff;
      oam_addr_in = oam_addr_ff; v_in = v_ff; t_in = t_ff;
      fine_x_in = fine_x_ff; toggle_in = toggle_ff; buf_in = buf_ff;
      name_we = 1'b0; spr_we = 1'b0; pal_we = 1'b0;
      rsp_in = '0;
      if (cmd.execute) begin
         case (req_ff.command)
            CMD_READ: begin
               case (req_ff.reg_select)
                  REG_CTRL: rsp_in.read_data = ctrl_ff;
                  REG_STATUS: begin
                     rsp_in.read_data = {status_ff, 5'd0} | (hit_ff ? 8'h40 : 8'h00);
                     status_in[2] = 1'b0;
                     toggle_in = 1'b0;
                  end
                  REG_OAMDATA: rsp_in.read_data = spr_rd_ff;
                  REG_DATA: begin
                     if (in_pal) begin
                        rsp_in.read_data = {2'b00, palette_ff[pal_addr]};
                        buf_in = {2'b00, palette_ff[pal_addr]};
                     end else if (in_pat) begin
                        rsp_in.read_data = buf_ff;
                        buf_in = 8'd0;
                        rsp_in.pattern_access = 1'b1;
                        rsp_in.pattern_address = v_ff[12:0];
                     end else begin
                        rsp_in.read_data = buf_ff;
                        buf_in = name_rd_ff;
                     end
                     v_in = v_step;
                  end
                  default: ;
               endcase
            end
            CMD_WRITE: begin
               case (req_ff.reg_select)
                  REG_CTRL: begin
                     ctrl_in = req_ff.write_data;
                     t_in[11:10] = req_ff.write_data[1:0];
                     rsp_in.nmi_pulse = !ctrl_ff[7] && req_ff.write_data[7] && status_ff[2];
                  end
                  REG_OAMADDR: oam_addr_in = req_ff.write_data;
                  REG_OAMDATA: begin
                     spr_we = 1'b1;
                     oam_addr_in = oam_addr_ff + 8'd1;
                  end
                  REG_SCROLL: begin
                     if (!toggle_ff) begin
                        t_in[4:0] = req_ff.write_data[7:3];
                        fine_x_in = req_ff.write_data[2:0];
                     end else begin
                        t_in[9:5] = req_ff.write_data[7:3];
                        t_in[14:12] = req_ff.write_data[2:0];
                     end
                     toggle_in = !toggle_ff;
                  end
                  REG_ADDR: begin
                     if (!toggle_ff) begin
                        t_in[14:8] = {1'b0, req_ff.write_data[5:0]};
                        toggle_in = 1'b1;
                     end else begin
                        t_in[7:0] = req_ff.write_data;
                        v_in = {1'b0, t_ff[14:8], req_ff.write_data};
                        toggle_in = 1'b0;
                     end
                  end
                  REG_DATA: begin
                     if (in_pal) pal_we = 1'b1;
                     else if (in_pat) begin
                        rsp_in.pattern_access = 1'b1;
                        rsp_in.pattern_address = v_ff[12:0];
                     end else name_we = 1'b1;
                     v_in = v_step;
                  end
                  default: ;
               endcase
            end
            CMD_VBLANK: begin
               status_in[2] = 1'b1;
               rsp_in.nmi_pulse = ctrl_ff[7];
            end
            CMD_PRERENDER: begin
               status_in = 3'd0;
               hit_in = 1'b0;
            end
            CMD_HIT: begin
               status_in[1] = 1'b1;
               hit_in = 1'b1;
            end
            CMD_OVERFLOW: status_in[0] = 1'b1;
            default: ;
         endcase
         rsp_in.scroll_address = v_in;
         rsp_in.fine_scroll_x = fine_x_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0; status_ff <= '0; hit_ff <= 1'b0; oam_addr_ff <= '0;
         v_ff <= '0; t_ff <= '0; fine_x_ff <= '0; toggle_ff <= 1'b0; buf_ff <= '0;
      end else begin
         ctrl_ff <= ctrl_in; status_ff <= status_in; hit_ff <= hit_in;
         oam_addr_ff <= oam_addr_in; v_ff <= v_in; t_ff <= t_in;
         fine_x_ff <= fine_x_in; toggle_ff <= toggle_in; buf_ff <= buf_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) rsp_ff <= rsp_in;
   end

   assign rsp_data = rsp_ff;
endmodule

/* verif/tb.sv */
// testbench for the video register port: directed table then random traffic
// predicts every response with its own model of registers and memories
// depends on vrp_pkg and video_register_port_top
`timescale 1ns / 1ps
module tb;
   import vrp_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_type req_data;
   logic rsp_valid;
   logic rsp_ready;
   rsp_type rsp_data;
   logic psel;
   logic penable;
   logic pwrite;
   logic [1:0] paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic pready;

   video_register_port_top DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // predicted copy of the block state
   logic [7:0] ctl_q;
   logic [2:0] flags_q;
   logic hit_q;
   logic [7:0] oam_ptr_q;
   logic [15:0] v_q;
   logic [14:0] t_q;
   logic [2:0] fx_q;
   logic toggle_q;
   logic [7:0] rbuf_q;
   logic [7:0] nt_mem [NAME_RAM_BYTES];
   logic [5:0] pal_mem [PALETTE_ENTRIES];
   logic [7:0] oam_mem [SPRITE_MEM_BYTES];
   logic [1:0] mirror_q;

   rsp_type pending_rsp [$];
   int errors;
   int tick_count;
   int stall_left;   // cycles left in the current rsp_ready stall
   bit quiet;        // last part of the run: no idling on either side

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      tick_count <= tick_count + 1;
      if (tick_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
   endtask

   function automatic logic [4:0] pal_slot(input logic [15:0] a);
      logic [4:0] i;
      i = a[4:0];
      if (i[4] && i[1:0] == 2'b00) i[4] = 1'b0;
      return i;
   endfunction

   function automatic logic [10:0] nt_slot(input logic [15:0] a);
      logic [11:0] rel;
      logic [1:0] tbl;
      logic bank;
      rel = a[11:0] - 12'h000;
      tbl = rel[11:10];
      case (mirror_q)
         2'd0: bank = tbl[1];
         2'd1: bank = tbl[0];
         2'd2: bank = 1'b0;
         default: bank = 1'b1;
      endcase
      return {bank, rel[9:0]};
   endfunction

   function automatic void clear_model();
      ctl_q = '0; flags_q = '0; hit_q = 1'b0; oam_ptr_q = '0; v_q = '0; t_q = '0;
      fx_q = '0; toggle_q = 1'b0; rbuf_q = '0; mirror_q = '0;
      foreach (nt_mem[i]) nt_mem[i] = '0;
      foreach (pal_mem[i]) pal_mem[i] = '0;
      foreach (oam_mem[i]) oam_mem[i] = '0;
   endfunction

   // advance the state by one transfer and return the response it causes
   function automatic rsp_type predict_access(input req_type r);
      rsp_type o;
      logic [7:0] got;
      logic [15:0] a;
      o = '0;
      a = v_q;
      if (r.command == CMD_READ) begin
         case (r.reg_select)
            REG_CTRL: o.read_data = ctl_q;
            REG_STATUS: begin
               o.read_data = {flags_q, 5'b0};
               if (hit_q) o.read_data[6] = 1'b1;
               flags_q[2] = 1'b0;
               toggle_q = 1'b0;
            end
            REG_OAMDATA: o.read_data = oam_mem[oam_ptr_q];
            REG_DATA: begin
               if (a >= 16'h3F00) got = {2'b00, pal_mem[pal_slot(a)]};
               else if (a < 16'h2000) begin
                  got = '0;
                  o.pattern_access = 1'b1;
                  o.pattern_address = a[12:0];
               end else got = nt_mem[nt_slot(a)];
               o.read_data = (a >= 16'h3F00) ? got : rbuf_q;
               rbuf_q = got;
               v_q = v_q + (ctl_q[2] ? 16'd32 : 16'd1);
            end
            default: o.read_data = '0;
         endcase
      end else if (r.command == CMD_WRITE) begin
         case (r.reg_select)
            REG_CTRL: begin
               if (!ctl_q[7] && r.write_data[7] && flags_q[2]) o.nmi_pulse = 1'b1;
               ctl_q = r.write_data;
               t_q[11:10] = r.write_data[1:0];
            end
            REG_OAMADDR: oam_ptr_q = r.write_data;
            REG_OAMDATA: begin
               oam_mem[oam_ptr_q] = r.write_data;
               oam_ptr_q = oam_ptr_q + 8'd1;
            end
            REG_SCROLL: begin
               if (!toggle_q) begin
                  t_q[4:0] = r.write_data[7:3];
                  fx_q = r.write_data[2:0];
               end else begin
                  t_q = {r.write_data[2:0], t_q[11:10], r.write_data[7:3], t_q[4:0]};
               end
               toggle_q = ~toggle_q;
            end
            REG_ADDR: begin
               if (!toggle_q) begin
                  t_q[14:8] = {1'b0, r.write_data[5:0]};
                  toggle_q = 1'b1;
               end else begin
                  t_q[7:0] = r.write_data;
                  v_q = {1'b0, t_q};
                  toggle_q = 1'b0;
               end
            end
            REG_DATA: begin
               if (a >= 16'h3F00) pal_mem[pal_slot(a)] = r.write_data[5:0];
               else if (a < 16'h2000) begin
                  o.pattern_access = 1'b1;
                  o.pattern_address = a[12:0];
               end else nt_mem[nt_slot(a)] = r.write_data;
               v_q = v_q + (ctl_q[2] ? 16'd32 : 16'd1);
            end
            default: ;
         endcase
      end else if (r.command == CMD_VBLANK) begin
         flags_q[2] = 1'b1;
         if (ctl_q[7]) o.nmi_pulse = 1'b1;
      end else if (r.command == CMD_PRERENDER) begin
         flags_q = '0;
         hit_q = 1'b0;
      end else if (r.command == CMD_HIT) begin
         flags_q[1] = 1'b1;
         hit_q = 1'b1;
      end else if (r.command == CMD_OVERFLOW) begin
         flags_q[0] = 1'b1;
      end
      o.scroll_address = v_q;
      o.fine_scroll_x = fx_q;
      return o;
   endfunction

   // response side: random stalls, compare against oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               report_mismatch("unexpected transfer", 64'(rsp_data), 64'd0);
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_data.read_data !== want.read_data)
                  report_mismatch("read_data", 64'(rsp_data.read_data),
                                  64'(want.read_data));
               if (rsp_data.nmi_pulse !== want.nmi_pulse)
                  report_mismatch("nmi_pulse", 64'(rsp_data.nmi_pulse),
                                  64'(want.nmi_pulse));
               if (rsp_data.pattern_access !== want.pattern_access)
                  report_mismatch("pattern_access", 64'(rsp_data.pattern_access),
                                  64'(want.pattern_access));
               if (rsp_data.pattern_address !== want.pattern_address)
                  report_mismatch("pattern_address", 64'(rsp_data.pattern_address),
                                  64'(want.pattern_address));
               if (rsp_data.scroll_address !== want.scroll_address)
                  report_mismatch("scroll_address", 64'(rsp_data.scroll_address),
                                  64'(want.scroll_address));
               if (rsp_data.fine_scroll_x !== want.fine_scroll_x)
                  report_mismatch("fine_scroll_x", 64'(rsp_data.fine_scroll_x),
                                  64'(want.fine_scroll_x));
            end
         end
         // stall bursts now and then; stall_left holds their length, drawn at random
         if (quiet) begin
            rsp_ready <= 1'b1;
            stall_left <= 0;
         end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            rsp_ready <= (stall_left == 1);
         end else if (rsp_ready && $urandom_range(0, 9) == 0) begin
            stall_left <= int'($urandom_range(1, 14));
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // one transfer; typed expectation replaces the predicted one if given
   task automatic send_item(input req_type r, input bit use_typed, input rsp_type typed);
      rsp_type p;
      int gap;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 14);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = predict_access(r);
      if (use_typed) begin
         typed.scroll_address = p.scroll_address;
         typed.fine_scroll_x = p.fine_scroll_x;
         if (typed !== p) report_mismatch("directed table row", 64'(typed), 64'(p));
         pending_rsp.push_back(typed);
      end else begin
         pending_rsp.push_back(p);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_mirror(input logic [1:0] mode);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= CSR_MIRROR; pwdata <= {30'b0, mode};
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      mirror_q = mode;
   endtask

   function automatic req_type mk(input logic [2:0] c, input logic [2:0] s,
                                  input logic [7:0] d);
      req_type r;
      r.command = c; r.reg_select = s; r.write_data = d;
      return r;
   endfunction

   // biased random item: mostly well-formed address and data port traffic
   function automatic req_type random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 25) return mk(CMD_WRITE, REG_ADDR, 8'($urandom_range(0, 255)));
      if (pick < 45) return mk(CMD_WRITE, REG_DATA, 8'($urandom_range(0, 255)));
      if (pick < 60) return mk(CMD_READ, REG_DATA, 8'($urandom));
      if (pick < 65) return mk(CMD_WRITE, REG_CTRL, 8'($urandom_range(0, 255)));
      if (pick < 75)
         return mk(CMD_WRITE, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      if (pick < 85)
         return mk(CMD_READ, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      return mk(3'($urandom_range(2, 7)), 3'($urandom_range(0, 7)),
                8'($urandom_range(0, 255)));
   endfunction

   typedef struct {
      req_type r;
      bit typed;
      logic [7:0] rd;
      logic nmi;
   } dir_row;

   dir_row dir_rows [$];

   function automatic void add_row(input req_type r, input bit typed,
                                   input logic [7:0] rd, input logic nmi);
      dir_row d;
      d.r = r; d.typed = typed; d.rd = rd; d.nmi = nmi;
      dir_rows.push_back(d);
   endfunction

   initial begin
      rsp_type t;
      req_type r;
      int n;
      int addr_hi;
      errors = 0; quiet = 1'b0;
      reset = 1'b1; req_valid = 1'b0; req_data = '0; rsp_ready = 1'b0;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      clear_model();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table; typed rows give read_data and nmi_pulse directly
      add_row(mk(CMD_READ, REG_CTRL, 8'h00), 1'b1, 8'h00, 1'b0);     // after reset
      add_row(mk(CMD_READ, REG_STATUS, 8'hFF), 1'b1, 8'h00, 1'b0);
      add_row(mk(CMD_VBLANK, REG_CTRL, 8'h00), 1'b1, 8'h00, 1'b0);   // vblank, nmi off
      add_row(mk(CMD_WRITE, REG_CTRL, 8'h80), 1'b1, 8'h00, 1'b1);    // enable rises in vblank
      add_row(mk(CMD_VBLANK, REG_CTRL, 8'h00), 1'b1, 8'h00, 1'b1);
      add_row(mk(CMD_HIT, REG_CTRL, 8'h00), 1'b1, 8'h00, 1'b0);
      add_row(mk(CMD_OVERFLOW, REG_CTRL, 8'h00), 1'b1, 8'h00, 1'b0);
      add_row(mk(CMD_READ, REG_STATUS, 8'h00), 1'b1, 8'hE0, 1'b0);   // all flags
      add_row(mk(CMD_PRERENDER, REG_CTRL, 8'h00), 1'b1, 8'h00, 1'b0);
      add_row(mk(CMD_WRITE, REG_SCROLL, 8'hFF), 1'b0, 8'h00, 1'b0);
      add_row(mk(CMD_WRITE, REG_SCROLL, 8'hFF), 1'b0, 8'h00, 1'b0);
      add_row(mk(CMD_WRITE, REG_ADDR, 8'hFF), 1'b0, 8'h00, 1'b0);    // palette window
      add_row(mk(CMD_WRITE, REG_ADDR, 8'h10), 1'b0, 8'h00, 1'b0);
      add_row(mk(CMD_WRITE, REG_DATA, 8'hFF), 1'b0, 8'h00, 1'b0);    // palette mirror alias
      add_row(mk(CMD_WRITE, REG_ADDR, 8'h3F), 1'b0, 8'h00, 1'b0);
      add_row(mk(CMD_WRITE, REG_ADDR, 8'h00), 1'b0, 8'h00, 1'b0);
      add_row(mk(CMD_READ, REG_DATA, 8'h00), 1'b1, 8'h3F, 1'b0);     // bypasses buffer
      add_row(mk(CMD_WRITE, REG_ADDR, 8'h00), 1'b0, 8'h00, 1'b0);    // pattern space
      add_row(mk(CMD_WRITE, REG_ADDR, 8'h00), 1'b0, 8'h00, 1'b0);
      add_row(mk(CMD_READ, REG_DATA, 8'h00), 1'b0, 8'h00, 1'b0);
      add_row(mk(CMD_WRITE, REG_OAMADDR, 8'hFF), 1'b0, 8'h00, 1'b0);
      add_row(mk(CMD_WRITE, REG_OAMDATA, 8'hA5), 1'b0, 8'h00, 1'b0); // pointer wraps
      add_row(mk(CMD_READ, REG_OAMDATA, 8'h00), 1'b0, 8'h00, 1'b0);
      add_row(mk(3'd6, REG_MASK, 8'hFF), 1'b1, 8'h00, 1'b0);         // unused command
      add_row(mk(3'd7, REG_DATA, 8'h00), 1'b1, 8'h00, 1'b0);
      foreach (dir_rows[i]) begin
         t = '0;
         t.read_data = dir_rows[i].rd;
         t.nmi_pulse = dir_rows[i].nmi;
         if (dir_rows[i].typed)
            send_item(dir_rows[i].r, 1'b1, t);
         else
            send_item(dir_rows[i].r, 1'b0, t);
      end

      // random phases, one per mirroring mode (extremes included), then a quiet one in mode 0
      for (int ph = 0; ph < 5; ph++) begin
         drain();
         write_mirror(ph == 4 ? 2'd0 : 2'(3 - ph));
         n = 0;
         if (ph == 4) quiet = 1'b1;
         if (ph == 2) begin
            // hold the sender until every response has come
            drain();
         end
         while (n < 265) begin
            // well-formed address setup into pattern, nametable or palette space, then data traffic
            if ($urandom_range(0, 3) == 0) begin
               addr_hi = $urandom_range(0, 3) == 0 ? 8'h3F : $urandom_range(8'h00, 8'h3F);
               t = '0;
               send_item(mk(CMD_READ, REG_STATUS, 8'h00), 1'b0, t);
               send_item(mk(CMD_WRITE, REG_ADDR, addr_hi[7:0]), 1'b0, t);
               send_item(mk(CMD_WRITE, REG_ADDR, 8'($urandom_range(0, 255))), 1'b0, t);
               n += 3;
            end
            r = random_item();
            t = '0;
            send_item(r, 1'b0, t);
            n++;
         end
      end

      drain();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule

/* sim.f */
+incdir+hdl
hdl/vrp_pkg.sv
hdl/vrp_ctrl.sv
hdl/vrp_datapath.sv
hdl/video_register_port_top.sv
verif/tb.sv
